FILE: sv/ghb_pkg.sv
// shared constants, opcodes and types for the gray histogram block
package ghb_pkg;

  localparam int GRAY_LEVELS = 256;
  localparam int MAX_PIXELS  = 1048576;

  localparam int OP_W    = 2;
  localparam int LEVEL_W = 8;
  localparam int COUNT_W = 21;
  localparam int ROW_W   = 21;
  localparam int PIXEL_W = 4;
  localparam int ADDR_W  = $clog2(GRAY_LEVELS);

  localparam logic [OP_W-1:0] OP_COUNT = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [PIXEL_W-1:0] BAR_FILL  = 4'd9;
  localparam logic [PIXEL_W-1:0] BAR_BLANK = 4'd0;

  localparam logic [LEVEL_W-1:0] TOP_RESET = 8'd255;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_PIXELS);

  // item held between memory read and write-back
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ROW_W-1:0] row;
    logic             level_ok;
  } stage_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic [COUNT_W-1:0] peak_count;
    logic [PIXEL_W-1:0] bar_pixel;
    logic               level_rejected;
  } result_t;

  typedef struct packed {
    logic               wr_en;
    logic [COUNT_W-1:0] wr_data;
    logic [COUNT_W-1:0] peak_next;
    logic               clear;
    result_t            result;
  } update_t;

endpackage

FILE: sv/ghb_channels.sv
// valid/ready channel interfaces for item input, result output and configuration
interface ghb_in_if;
  logic                         valid;
  logic                         ready;
  logic [ghb_pkg::OP_W-1:0]    opcode;
  logic [ghb_pkg::LEVEL_W-1:0] gray_value;
  logic [ghb_pkg::ROW_W-1:0]   bar_row;

  modport source (output valid, opcode, gray_value, bar_row, input ready);
  modport sink   (input valid, opcode, gray_value, bar_row, output ready);
endinterface

interface ghb_out_if;
  logic                         valid;
  logic                         ready;
  logic [ghb_pkg::COUNT_W-1:0] bin_count;
  logic [ghb_pkg::COUNT_W-1:0] peak_count;
  logic [ghb_pkg::PIXEL_W-1:0] bar_pixel;
  logic                         level_rejected;

  modport source (output valid, bin_count, peak_count, bar_pixel, level_rejected,
                  input ready);
  modport sink   (input valid, bin_count, peak_count, bar_pixel, level_rejected,
                  output ready);
endinterface

interface ghb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ghb_pkg::LEVEL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: sv/ghb_ram.sv
// generic single-write, single-read ram with registered read data
module ghb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/ghb_calc.sv
// bin update, peak tracking and bar pixel decision for one item
module ghb_calc (
  input  ghb_pkg::stage_t                stage,
  input  logic [ghb_pkg::COUNT_W-1:0]    old_count,
  input  logic [ghb_pkg::COUNT_W-1:0]    peak,
  output ghb_pkg::update_t               upd
);

  logic [ghb_pkg::COUNT_W-1:0] cnt_inc;
  logic [ghb_pkg::COUNT_W-1:0] peak_up;

  // saturating increment
  assign cnt_inc = (old_count < ghb_pkg::COUNT_LIMIT) ? old_count + 1'b1 : old_count;
  assign peak_up = (cnt_inc > peak) ? cnt_inc : peak;

  always_comb begin
    upd = '0;
    upd.peak_next = peak;
    case (stage.op)
      ghb_pkg::OP_COUNT: begin
        upd.result.peak_count = peak;
        if (stage.level_ok) begin
          upd.wr_en             = 1'b1;
          upd.wr_data           = cnt_inc;
          upd.peak_next         = peak_up;
          upd.result.bin_count  = cnt_inc;
          upd.result.peak_count = peak_up;
        end else begin
          upd.result.level_rejected = 1'b1;
        end
      end
      ghb_pkg::OP_QUERY: begin
        upd.result.peak_count = peak;
        if (stage.level_ok) begin
          upd.result.bin_count = old_count;
          if (old_count <= peak && stage.row < peak - old_count) begin
            upd.result.bar_pixel = ghb_pkg::BAR_BLANK;
          end else begin
            upd.result.bar_pixel = ghb_pkg::BAR_FILL;
          end
        end else begin
          upd.result.level_rejected = 1'b1;
        end
      end
      ghb_pkg::OP_CLEAR: begin
        upd.clear     = 1'b1;
        upd.peak_next = '0;
      end
      default: begin
        upd.peak_next = peak;
      end
    endcase
  end

endmodule

FILE: sv/gray_histogram_bar_render.sv
// gray-level histogram with peak tracking and bar-chart pixel readout
// result: bin memory read with stage capture, then write-back into the output register
// one item at a time in the read stage, set by the bin memory read then write-back
// reset: bin valid flags, peak and control cleared, top level 255
// clear opcode empties all bins through the valid flags, no sweep
module gray_histogram_bar_render (
  input  logic      clk,
  input  logic      rst,
  ghb_in_if.sink    in_ch,
  ghb_out_if.source out_ch,
  ghb_cfg_if.sink   cfg_ch
);

  // configuration: highest gray level in use
  logic [ghb_pkg::LEVEL_W-1:0] top_level;

  // control: one item in the read stage at a time
  logic busy;
  logic in_acc;
  logic out_pop;

  // bin store: ram holds counts, per-bin valid flags give the cleared value
  logic [ghb_pkg::GRAY_LEVELS-1:0] bin_vld;
  logic [ghb_pkg::ADDR_W-1:0]      rd_addr;
  logic [ghb_pkg::ADDR_W-1:0]      st_addr;
  logic [ghb_pkg::COUNT_W-1:0]     ram_rdata;
  logic                            st_vld;
  logic [ghb_pkg::COUNT_W-1:0]     old_count;

  logic [ghb_pkg::COUNT_W-1:0] peak;

  ghb_pkg::stage_t  stage;
  ghb_pkg::update_t upd;
  logic             level_ok;

  // accept only out of reset, with the read stage free and the output register
  // free or draining
  assign in_ch.ready  = !rst && !busy && (!out_ch.valid || out_ch.ready);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_pop      = out_ch.valid && out_ch.ready;
  assign cfg_ch.ready = !rst;

  assign rd_addr = in_ch.gray_value[ghb_pkg::ADDR_W-1:0];

  // level in use and inside the store
  assign level_ok = (in_ch.gray_value <= top_level) &&
                    ((ghb_pkg::LEVEL_W+1)'(in_ch.gray_value) <
                     (ghb_pkg::LEVEL_W+1)'(ghb_pkg::GRAY_LEVELS));

  // never-written or cleared bins read as zero
  assign old_count = st_vld ? ram_rdata : '0;

  ghb_ram #(
    .WIDTH (ghb_pkg::COUNT_W),
    .DEPTH (ghb_pkg::GRAY_LEVELS)
  ) u_bins (
    .clk   (clk),
    .we    (busy && upd.wr_en),
    .waddr (st_addr),
    .wdata (upd.wr_data),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  ghb_calc u_calc (
    .stage     (stage),
    .old_count (old_count),
    .peak      (peak),
    .upd       (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      top_level <= ghb_pkg::TOP_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      top_level <= cfg_ch.data;
    end
  end

  // stage capture alongside the memory read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stage.op       <= in_ch.opcode;
      stage.row      <= in_ch.bar_row;
      stage.level_ok <= level_ok;
      st_addr        <= rd_addr;
      st_vld         <= bin_vld[rd_addr];
    end
  end

  // write-back stage: valid flags, peak and busy interlock
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bin_vld <= '0;
      peak    <= '0;
    end else begin
      busy <= in_acc;
      if (busy) begin
        peak <= upd.peak_next;
        if (upd.clear) begin
          bin_vld <= '0;
        end else if (upd.wr_en) begin
          bin_vld[st_addr] <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (busy) begin
      out_ch.valid <= 1'b1;
    end else if (out_pop) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      out_ch.bin_count      <= upd.result.bin_count;
      out_ch.peak_count     <= upd.result.peak_count;
      out_ch.bar_pixel      <= upd.result.bar_pixel;
      out_ch.level_rejected <= upd.result.level_rejected;
    end
  end

`ifndef SYNTH
  // a new result appears only right after an item left the read stage
  a_result_follows_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(busy))
    else $error("result without a preceding read stage");

  // interlock: no item taken while one is in the read stage
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(in_ch.valid && in_ch.ready))
    else $error("item accepted while read stage busy");

  // the peak is never below any reported bin count
  a_peak_bounds_bin: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.bin_count <= out_ch.peak_count)
    else $error("bin count above peak");

  // a rejected level reports no bin and a blank pixel
  a_rejected_blank: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.level_rejected) |->
      (out_ch.bin_count == '0 && out_ch.bar_pixel == ghb_pkg::BAR_BLANK))
    else $error("rejected level with nonzero bin fields");
`endif

endmodule

FILE: sim/testbench.sv
// self-checking testbench for the gray-level histogram with bar-chart readout
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // opcode left unused by the block, items carrying it are ignored
  localparam logic [ghb_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst;

  ghb_in_if  in_ch();
  ghb_out_if out_ch();
  ghb_cfg_if cfg_ch();

  gray_histogram_bar_render u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow copy of the histogram, the peak and the top level register
  logic [ghb_pkg::COUNT_W-1:0] bin_tally [ghb_pkg::GRAY_LEVELS];
  logic [ghb_pkg::COUNT_W-1:0] tallest;
  logic [ghb_pkg::LEVEL_W-1:0] top_level;

  // readouts owed by the block, oldest first
  ghb_pkg::result_t readout_queue[$];

  int mismatch_count;
  bit idling;

  always #5 clk = ~clk;

  // all inputs known from time zero, reset held high at the start
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = ghb_pkg::OP_COUNT;
    in_ch.gray_value = '0;
    in_ch.bar_row    = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = ghb_pkg::TOP_RESET;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // one step of the histogram: updates the shadow state, returns the readout
  function automatic ghb_pkg::result_t tally_and_read(
      input logic [ghb_pkg::OP_W-1:0] op,
      input logic [ghb_pkg::LEVEL_W-1:0] level,
      input logic [ghb_pkg::ROW_W-1:0] row);
    ghb_pkg::result_t r;
    logic in_use;
    r = '0;
    in_use = (level <= top_level) && (int'(level) < ghb_pkg::GRAY_LEVELS);
    case (op)
      ghb_pkg::OP_COUNT: begin
        r.peak_count = tallest;
        if (in_use) begin
          // bins stick at the pixel limit
          if (bin_tally[level] < ghb_pkg::COUNT_LIMIT) begin
            bin_tally[level] = bin_tally[level] + 1'b1;
          end
          if (bin_tally[level] > tallest) tallest = bin_tally[level];
          r.bin_count  = bin_tally[level];
          r.peak_count = tallest;
        end else begin
          r.level_rejected = 1'b1;
        end
      end
      ghb_pkg::OP_QUERY: begin
        r.peak_count = tallest;
        if (in_use) begin
          r.bin_count = bin_tally[level];
          // blank above the bar, filled from the bar top down and past the image
          if (bin_tally[level] <= tallest && row < tallest - bin_tally[level]) begin
            r.bar_pixel = ghb_pkg::BAR_BLANK;
          end else begin
            r.bar_pixel = ghb_pkg::BAR_FILL;
          end
        end else begin
          r.level_rejected = 1'b1;
        end
      end
      ghb_pkg::OP_CLEAR: begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
        tallest = '0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void note_mismatch(input string what, input ghb_pkg::result_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t mismatch (%s): expected count %0d peak %0d pixel %0d rej %0d,",
               $realtime, what, want.bin_count, want.peak_count, want.bar_pixel,
               want.level_rejected);
      $display("    got count %0d peak %0d pixel %0d rej %0d",
               out_ch.bin_count, out_ch.peak_count, out_ch.bar_pixel,
               out_ch.level_rejected);
    end
  endfunction

  // result side: every accepted readout is matched against the oldest one owed
  always @(posedge clk) begin : check_readout
    ghb_pkg::result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (readout_queue.size() == 0) begin
        note_mismatch("no readout owed", '0);
      end else begin
        want = readout_queue.pop_front();
        if (out_ch.bin_count !== want.bin_count) note_mismatch("bin_count", want);
        if (out_ch.peak_count !== want.peak_count) note_mismatch("peak_count", want);
        if (out_ch.bar_pixel !== want.bar_pixel) note_mismatch("bar_pixel", want);
        if (out_ch.level_rejected !== want.level_rejected) begin
          note_mismatch("level_rejected", want);
        end
      end
    end
  end

  // result side back-pressure: random stall bursts while idling is on
  initial begin
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20) - 1) @(posedge clk);
    end
  end

  // offer one item, wait for acceptance, then book its readout
  // valid stays high on return so back-to-back items need no gap
  task automatic send_item(input logic [ghb_pkg::OP_W-1:0] op,
                           input logic [ghb_pkg::LEVEL_W-1:0] level,
                           input logic [ghb_pkg::ROW_W-1:0] row);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.gray_value <= level;
    in_ch.bar_row    <= row;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    readout_queue.push_back(tally_and_read(op, level, row));
  endtask

  // stop offering items and let every owed readout come back
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (readout_queue.size() != 0) @(posedge clk);
  endtask

  // top level register write, only while the block is idle
  task automatic write_top(input logic [ghb_pkg::LEVEL_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    top_level = value;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // empty histogram straight after reset, widest rows, ignored opcode
  task automatic test_reset_readout();
    send_item(ghb_pkg::OP_QUERY, 8'd0, '0);
    send_item(ghb_pkg::OP_QUERY, 8'd255, {ghb_pkg::ROW_W{1'b1}});
    send_item(OP_UNUSED, 8'd255, {ghb_pkg::ROW_W{1'b1}});
    finish_phase();
  endtask

  // counts at both ends of the level range and bar pixels around the bar top
  task automatic test_count_and_bars();
    send_item(ghb_pkg::OP_COUNT, 8'd0, '0);
    send_item(ghb_pkg::OP_COUNT, 8'd0, {ghb_pkg::ROW_W{1'b1}});
    send_item(ghb_pkg::OP_COUNT, 8'd255, '0);
    send_item(ghb_pkg::OP_COUNT, 8'd7, '0);
    send_item(ghb_pkg::OP_QUERY, 8'd0, '0);        // tallest bar, filled at the top row
    send_item(ghb_pkg::OP_QUERY, 8'd7, '0);        // just above the bar top
    send_item(ghb_pkg::OP_QUERY, 8'd7, 21'd1);     // bar top row
    send_item(ghb_pkg::OP_QUERY, 8'd128, 21'd1);   // empty bin, blank above
    send_item(ghb_pkg::OP_QUERY, 8'd128, {ghb_pkg::ROW_W{1'b1}}); // row past the image
    finish_phase();
  endtask

  // lowered top rejects high levels, hidden bins still set the peak
  task automatic test_top_level();
    write_top(8'd1);
    send_item(ghb_pkg::OP_COUNT, 8'd2, '0);
    send_item(ghb_pkg::OP_COUNT, 8'd1, '0);
    send_item(ghb_pkg::OP_QUERY, 8'd255, '0);
    send_item(ghb_pkg::OP_QUERY, 8'd1, '0);
    finish_phase();
    write_top(8'd0);
    send_item(ghb_pkg::OP_COUNT, 8'd0, '0);
    send_item(ghb_pkg::OP_COUNT, 8'd1, '0);
    send_item(ghb_pkg::OP_QUERY, 8'd0, 21'd1);
    finish_phase();
    // raising the top shows the old counts again
    write_top(ghb_pkg::TOP_RESET);
    send_item(ghb_pkg::OP_QUERY, 8'd255, '0);
    finish_phase();
  endtask

  // clear wipes bins and peak, unused opcode leaves state alone
  task automatic test_clear();
    send_item(ghb_pkg::OP_CLEAR, 8'd255, {ghb_pkg::ROW_W{1'b1}});
    send_item(ghb_pkg::OP_QUERY, 8'd0, '0);
    send_item(ghb_pkg::OP_COUNT, 8'd255, '0);
    send_item(OP_UNUSED, 8'd0, '0);
    finish_phase();
  endtask

  // levels mostly in use and crowded onto a few bins so bars grow tall
  function automatic logic [ghb_pkg::LEVEL_W-1:0] pick_level();
    logic [ghb_pkg::LEVEL_W-1:0] hot_top;
    hot_top = (top_level < 8'd3) ? top_level : 8'd3;
    case ($urandom_range(0, 9))
      0: return ghb_pkg::LEVEL_W'($urandom());
      1: return (top_level == 8'hFF) ? top_level : top_level + 1'b1;
      2, 3, 4, 5: return ghb_pkg::LEVEL_W'($urandom_range(0, hot_top));
      default: return ghb_pkg::LEVEL_W'($urandom_range(0, top_level));
    endcase
  endfunction

  // random mix under one top level; rows cluster around each bar top
  task automatic test_random_phase(input int n_items,
                                   input logic [ghb_pkg::LEVEL_W-1:0] top,
                                   input bit with_idling);
    logic [ghb_pkg::OP_W-1:0]    op;
    logic [ghb_pkg::LEVEL_W-1:0] level;
    logic [ghb_pkg::ROW_W-1:0]   row;
    logic [ghb_pkg::COUNT_W-1:0] gap;
    int pick;
    idling = with_idling;
    write_top(top);
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) op = OP_UNUSED;
      else if (pick < 3) op = ghb_pkg::OP_CLEAR;
      else if (pick < 38) op = ghb_pkg::OP_QUERY;
      else op = ghb_pkg::OP_COUNT;
      level = pick_level();
      gap = (tallest >= bin_tally[level]) ? tallest - bin_tally[level] : '0;
      case ($urandom_range(0, 5))
        0: row = gap - 1'b1;   // wraps to all ones on the tallest bar
        1: row = gap;
        2: row = gap + 1'b1;
        3: row = ghb_pkg::ROW_W'($urandom_range(0, int'(tallest)));
        default: row = ghb_pkg::ROW_W'($urandom());
      endcase
      send_item(op, level, row);
    end
    finish_phase();
  endtask

  initial begin
    foreach (bin_tally[i]) bin_tally[i] = '0;
    tallest        = '0;
    top_level      = ghb_pkg::TOP_RESET;
    mismatch_count = 0;
    idling         = 1'b1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_readout();
    test_count_and_bars();
    test_top_level();
    test_clear();

    test_random_phase(300, 8'd255, 1'b1);
    test_random_phase(200, 8'd1, 1'b1);
    test_random_phase(150, 8'd0, 1'b1);
    test_random_phase(300, ghb_pkg::LEVEL_W'($urandom_range(2, 254)), 1'b1);
    test_random_phase(250, ghb_pkg::LEVEL_W'($urandom_range(2, 254)), 1'b1);
    test_random_phase(250, 8'd255, 1'b1);
    // closing stretch at full rate on both sides
    test_random_phase(300, ghb_pkg::LEVEL_W'($urandom_range(1, 255)), 1'b0);

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && readout_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
